/* hdl/vfc_pkg.sv */
// Package for the six-plane frustum culler: command codes, widths, plane source tables.
// No dependencies.
`default_nettype none
package vfc_pkg;
	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_POINT  = 2'd1,
		CMD_SPHERE = 2'd2,
		CMD_CUBE   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [1:0]         row_index;
		logic signed [31:0] row_elem_0;
		logic signed [31:0] row_elem_1;
		logic signed [31:0] row_elem_2;
		logic signed [31:0] row_elem_3;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [30:0]        extent;
	} item_t;

	typedef struct packed {
		logic inside_res;
	} res_t;

	function automatic logic [1:0] src_row(input logic [2:0] p);
		return p[2:1];
	endfunction

	function automatic logic src_sub(input logic [2:0] p);
		case (p)
			3'd0, 3'd3, 3'd4: return 1'b1;
			default:          return 1'b0;
		endcase
	endfunction
endpackage
`default_nettype wire

/* hdl/vfc_if.sv */
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface vfc_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/view_frustum_cull.sv */
// Six-plane view frustum culler, signed Q16.16, top level.
// A test walks the four elements of each plane in turn, for a cube over up to eight corners;
// a load normalises each plane with a bit-serial square root and the 49-step divider.
// One transaction at a time; input waits while a result is held. Reset clears control
// state and then sweeps both memories to zero.
`default_nettype none
module view_frustum_cull #(
	parameter int PLANE_COUNT = 6
) (
	input  wire logic clk,
	input  wire logic arst_n,
	vfc_if.sink       in_ch,
	vfc_if.source     out_ch
);
	import vfc_pkg::*;

	localparam int PW = $clog2(PLANE_COUNT * 4);

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_WROW, ST_RB_RD, ST_RB_RW, ST_RB_RK, ST_RB_ADD,
		ST_SQ, ST_SQRT, ST_DIV_GO, ST_DIV_WT, ST_PL_WR, ST_T_RD, ST_T_MUL,
		ST_T_ACC, ST_T_PL, ST_OUT
	} state_t;

	state_t state_q;
	item_t  it_q;

	logic signed [31:0] mrow_mem [16];
	logic signed [31:0] pl_mem [PLANE_COUNT * 4];
	logic signed [31:0] mrd_s1, prd_s1;
	logic [3:0]  maddr_q;
	logic [PW-1:0] paddr_q;
	logic [4:0]  clr_q;

	logic [2:0]  p_q;
	logic [2:0]  e_q;
	logic [1:0]  cw_q;
	logic signed [32:0] raw_q [4];
	logic signed [31:0] wv_q;
	logic [67:0] s_q;
	logic [35:0] mag_q, cand_q;
	logic [5:0]  sb_q;
	logic [71:0] sqr_q;
	logic        sq_ph_q;

	logic        dv_start;
	logic        dv_done;
	logic [48:0] dv_quo;
	logic [48:0] dv_num;

	logic [2:0]  c_q;
	logic [1:0]  k_q;
	logic signed [32:0] mop_q;
	logic signed [31:0] pe_q;
	logic signed [65:0] prod_s1;
	logic signed [67:0] acc_q;
	logic        any_q, inside_q;
	logic        res_v_q;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647) return 32'sh7fffffff;
		if (v < -50'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [32:0] abs33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	logic signed [32:0] raw_e;
	logic [32:0] abs_e;
	assign raw_e = raw_q[e_q[1:0]];
	assign abs_e = abs33(raw_e);
	assign dv_num = {abs_e, 16'd0} + {14'd0, mag_q[35:1]};

	vfc_divu u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num),
		.den(mag_q), .done(dv_done), .quo(dv_quo)
	);
	assign dv_start = (state_q == ST_DIV_GO);

	logic signed [32:0] crn;
	always_comb begin
		case (k_q)
			2'd0: crn = c_q[0] ? 33'(it_q.pos_x) + 33'(it_q.extent)
				: 33'(it_q.pos_x) - 33'(it_q.extent);
			2'd1: crn = c_q[1] ? 33'(it_q.pos_y) + 33'(it_q.extent)
				: 33'(it_q.pos_y) - 33'(it_q.extent);
			2'd2: crn = c_q[2] ? 33'(it_q.pos_z) + 33'(it_q.extent)
				: 33'(it_q.pos_z) - 33'(it_q.extent);
			default: crn = 33'sd65536;
		endcase
		if (it_q.cmd != CMD_CUBE && k_q != 2'd3) begin
			case (k_q)
				2'd0: crn = 33'(it_q.pos_x);
				2'd1: crn = 33'(it_q.pos_y);
				default: crn = 33'(it_q.pos_z);
			endcase
		end
	end

	logic mem_we;
	logic [3:0] mwa;
	logic signed [31:0] mwd;
	logic pl_we;
	logic [PW-1:0] pwa;
	logic signed [31:0] pwd;

	always_ff @(posedge clk) begin
		if (mem_we) mrow_mem[mwa] <= mwd;
		if (pl_we) pl_mem[pwa] <= pwd;
		mrd_s1 <= mrow_mem[maddr_q];
		prd_s1 <= pl_mem[paddr_q];
		prod_s1 <= mop_q * pe_q;
	end

	always_comb begin
		mem_we = 1'b0; mwa = clr_q[3:0]; mwd = '0;
		pl_we = 1'b0; pwa = clr_q[PW-1:0]; pwd = '0;
		if (state_q == ST_CLR) begin
			mem_we = (clr_q < 5'd16);
			pl_we  = 1'b1;
		end else if (state_q == ST_WROW) begin
			mem_we = 1'b1;
			mwa = {it_q.row_index, cw_q};
			case (cw_q)
				2'd0: mwd = it_q.row_elem_0;
				2'd1: mwd = it_q.row_elem_1;
				2'd2: mwd = it_q.row_elem_2;
				default: mwd = it_q.row_elem_3;
			endcase
		end else if (state_q == ST_PL_WR) begin
			pl_we = 1'b1;
			pwa = PW'({p_q, 2'b00} + {3'd0, e_q[1:0]});
			pwd = wv_q;
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !res_v_q;
	assign out_ch.valid = res_v_q;
	assign out_ch.data.inside_res = inside_q;

	logic [71:0] cand_sq;
	assign cand_sq = {36'd0, cand_q} * {36'd0, cand_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (res_v_q && out_ch.ready) res_v_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 5'd1;
					if (clr_q == 5'(PLANE_COUNT * 4 - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						it_q <= in_ch.data;
						cw_q <= '0; p_q <= '0; c_q <= '0; k_q <= '0;
						any_q <= 1'b0; inside_q <= 1'b1;
						acc_q <= '0;
						paddr_q <= '0;
						state_q <= (in_ch.data.cmd == CMD_LOAD) ? ST_WROW : ST_T_RD;
					end
				end
				ST_WROW: begin
					cw_q <= cw_q + 2'd1;
					if (cw_q == 2'd3) begin
						p_q <= '0; e_q <= '0;
						state_q <= ST_RB_RD;
					end
				end
				ST_RB_RD: begin
					maddr_q <= {2'd3, e_q[1:0]};
					state_q <= ST_RB_RW;
				end
				ST_RB_RW: begin
					maddr_q <= {src_row(p_q), e_q[1:0]};
					state_q <= ST_RB_RK;
				end
				ST_RB_RK: begin
					wv_q <= mrd_s1;
					state_q <= ST_RB_ADD;
				end
				ST_RB_ADD: begin
					raw_q[e_q[1:0]] <= src_sub(p_q) ? 33'(wv_q) - 33'(mrd_s1)
						: 33'(wv_q) + 33'(mrd_s1);
					if (e_q == 3'd3) begin
						e_q <= '0; s_q <= '0; sq_ph_q <= 1'b0;
						state_q <= ST_SQ;
					end else begin
						e_q <= e_q + 3'd1;
						state_q <= ST_RB_RD;
					end
				end
				ST_SQ: begin
					if (!sq_ph_q) begin
						sqr_q <= {39'd0, abs_e} * {39'd0, abs_e};
						sq_ph_q <= 1'b1;
					end else begin
						s_q <= s_q + sqr_q[67:0];
						sq_ph_q <= 1'b0;
						if (e_q == 3'd2) begin
							e_q <= '0; mag_q <= '0; sb_q <= 6'd35;
							cand_q <= 36'h800000000;
							state_q <= ST_SQRT;
						end else e_q <= e_q + 3'd1;
					end
				end
				ST_SQRT: begin
					if (s_q == '0) begin
						e_q <= '0;
						wv_q <= sat32(50'(raw_q[0]));
						state_q <= ST_PL_WR;
					end else begin
						if (!sq_ph_q) begin
							sqr_q <= cand_sq;
							sq_ph_q <= 1'b1;
						end else begin
							sq_ph_q <= 1'b0;
							if (sqr_q <= {4'd0, s_q}) mag_q <= cand_q;
							if (sb_q == 6'd0) state_q <= ST_DIV_GO;
							else begin
								cand_q <= ((sqr_q <= {4'd0, s_q}) ? cand_q : mag_q)
									| (36'd1 << (sb_q - 6'd1));
								sb_q <= sb_q - 6'd1;
							end
						end
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WT;
				ST_DIV_WT: begin
					if (dv_done) begin
						wv_q <= sat32(raw_e[32] ? -$signed({1'b0, dv_quo})
							: $signed({1'b0, dv_quo}));
						state_q <= ST_PL_WR;
					end
				end
				ST_PL_WR: begin
					if (e_q == 3'd3) begin
						e_q <= '0;
						if (p_q == 3'(PLANE_COUNT - 1)) state_q <= ST_IDLE;
						else begin
							p_q <= p_q + 3'd1;
							state_q <= ST_RB_RD;
						end
					end else begin
						e_q <= e_q + 3'd1;
						if (s_q == '0) begin
							wv_q <= sat32(50'(raw_q[e_q[1:0] + 2'd1]));
							state_q <= ST_PL_WR;
						end else state_q <= ST_DIV_GO;
					end
				end
				ST_T_RD: begin
					paddr_q <= PW'({p_q, 2'b00} + {3'd0, k_q});
					state_q <= ST_T_MUL;
				end
				ST_T_MUL: begin
					mop_q <= crn;
					state_q <= ST_T_ACC;
				end
				ST_T_ACC: begin
					pe_q <= prd_s1;
					state_q <= ST_T_PL;
					sq_ph_q <= 1'b0;
				end
				ST_T_PL: begin
					if (!sq_ph_q) sq_ph_q <= 1'b1;
					else begin
						logic signed [67:0] nacc;
						logic pos;
						nacc = acc_q + 68'(prod_s1);
						if (k_q == 2'd3 && it_q.cmd == CMD_SPHERE)
							nacc = nacc + 68'({it_q.extent, 16'd0});
						if (k_q != 2'd3) begin
							acc_q <= nacc;
							k_q <= k_q + 2'd1;
							state_q <= ST_T_RD;
						end else begin
							pos = !nacc[67] && nacc != '0;
							acc_q <= '0;
							k_q <= '0;
							if (it_q.cmd == CMD_CUBE && !pos && c_q != 3'd7) begin
								c_q <= c_q + 3'd1;
								state_q <= ST_T_RD;
							end else begin
								c_q <= '0;
								if (!pos) begin
									inside_q <= 1'b0;
									state_q <= ST_OUT;
								end else if (p_q == 3'(PLANE_COUNT - 1)) state_q <= ST_OUT;
								else begin
									p_q <= p_q + 3'd1;
									state_q <= ST_T_RD;
								end
							end
						end
					end
				end
				ST_OUT: begin
					res_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/vfc_divu.sv */
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module vfc_divu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [48:0] num,
	input  wire logic [35:0] den,
	output logic             done,
	output logic [48:0]      quo
);
	logic [36:0] rem_q;
	logic [48:0] n_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [36:0] trial;

	assign trial = {rem_q[35:0], n_q[48]} - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd49;
				rem_q  <= '0;
				n_q    <= num;
			end else if (busy_q) begin
				if (!trial[36]) begin
					rem_q <= trial;
					n_q   <= {n_q[47:0], 1'b1};
				end else begin
					rem_q <= {rem_q[35:0], n_q[48]};
					n_q   <= {n_q[47:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	assign quo = n_q;
endmodule
`default_nettype wire
